// ===== rtl/ilp_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer literal parser package
// Widths, phase codes, character codes and digit classification.
// ----------------------------------------------------------------------------
package ilp_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_WIDTH = 16;
	localparam int BASE_WIDTH  = 6;
	localparam int CHAR_WIDTH  = 8;
	localparam int OUT_WIDTH   = ((VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

	localparam logic [BASE_WIDTH-1:0] BASE_AUTO    = BASE_WIDTH'(0);
	localparam logic [BASE_WIDTH-1:0] BASE_OCT     = BASE_WIDTH'(8);
	localparam logic [BASE_WIDTH-1:0] BASE_DEC     = BASE_WIDTH'(10);
	localparam logic [BASE_WIDTH-1:0] BASE_HEX     = BASE_WIDTH'(16);
	localparam logic [BASE_WIDTH-1:0] BASE_RESET   = BASE_DEC;

	localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_WIDTH-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_WIDTH-1:0] CH_VT    = 8'h0B;
	localparam logic [CHAR_WIDTH-1:0] CH_FF    = 8'h0C;
	localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_WIDTH-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_WIDTH-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_WIDTH-1:0] CH_LZ    = 8'h7A;

	typedef enum logic [2:0] {
		PH_SPACE  = 3'd0,
		PH_SIGNED = 3'd1,
		PH_ZERO   = 3'd2,
		PH_DIGITS = 3'd3
	} phase_t;

	typedef struct packed {
		logic                  ok;
		logic [BASE_WIDTH-1:0] val;
	} digit_t;

	function automatic digit_t digit_of(input logic [CHAR_WIDTH-1:0] c);
		digit_t d;
		logic [CHAR_WIDTH-1:0] t;
		d = '0;
		t = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			t = c - CH_ZERO;
			d.ok = 1'b1;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			t = c - CH_LA + CHAR_WIDTH'(10);
			d.ok = 1'b1;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			t = c - CH_UA + CHAR_WIDTH'(10);
			d.ok = 1'b1;
		end
		d.val = t[BASE_WIDTH-1:0];
		return d;
	endfunction

	function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
			c == CH_FF || c == CH_VT;
	endfunction

endpackage

// ===== rtl/integer_literal_parser_core.sv =====
// Takes one byte per transfer and returns one result per literal, on the byte that ends it:
// the value (negated if a minus sign led) and the count of bytes consumed before that byte.
// Sustains one byte per clock unless a result waits untaken; a byte is held in the input
// register, and its result is registered into the output register as the byte advances. The
// output register holds a result until it is taken, and s_axis_tready follows m_axis_tready
// while a result waits and a byte is held. number_base is latched from the register when the
// first byte after whitespace and sign is seen.
// ----------------------------------------------------------------------------
// Integer literal parser core
// Single-pass byte classifier and multiply-accumulate with registered result.
// ----------------------------------------------------------------------------
module integer_literal_parser_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [ilp_pkg::CHAR_WIDTH-1:0]     s_axis_tdata,  // [7:0] character
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [ilp_pkg::OUT_WIDTH-1:0]      m_axis_tdata,  // [31:0] value, [47:32] consumed_count
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ilp_pkg::BASE_WIDTH-1:0]     cfg_data       // [5:0] number_base
);
	import ilp_pkg::*;

	logic                   valid_s1;
	logic [CHAR_WIDTH-1:0]  char_s1;
	logic                   advance;

	logic [BASE_WIDTH-1:0]  number_base_q;
	phase_t                 phase_q, phase_d;
	logic [VALUE_WIDTH-1:0] acc_q, acc_d;
	logic                   neg_q, neg_d;
	logic [BASE_WIDTH-1:0]  base_q, base_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;

	logic                   out_valid_q;
	logic [OUT_WIDTH-1:0]   out_data_q, out_data_d;

	logic                   try_start, try_digit, bump, emit;
	logic [BASE_WIDTH-1:0]  dig_base;
	digit_t                 dig;
	logic [VALUE_WIDTH+BASE_WIDTH-1:0] prod;
	logic [COUNT_WIDTH-1:0] count_inc;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign dig       = digit_of(char_s1);
	assign prod      = (VALUE_WIDTH+BASE_WIDTH)'(acc_q) * (VALUE_WIDTH+BASE_WIDTH)'(dig_base);
	assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_WIDTH'(1);

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		neg_d     = neg_q;
		base_d    = base_q;
		count_d   = count_q;
		try_start = 1'b0;
		try_digit = 1'b0;
		bump      = 1'b0;
		emit      = 1'b0;
		dig_base  = base_q;
		unique case (phase_q)
			PH_SIGNED: try_start = 1'b1;
			PH_ZERO: begin
				if (char_s1 == CH_LX || char_s1 == CH_UX) begin
					base_d  = BASE_HEX;
					bump    = 1'b1;
					phase_d = PH_DIGITS;
				end else begin
					dig_base  = (base_q == BASE_AUTO) ? BASE_OCT : BASE_HEX;
					try_digit = 1'b1;
				end
			end
			PH_DIGITS: try_digit = 1'b1;
			default: begin
				phase_d = PH_SPACE;
				if (is_space(char_s1)) begin
					bump = 1'b1;
				end else if (char_s1 == CH_PLUS || char_s1 == CH_MINUS) begin
					neg_d   = (char_s1 == CH_MINUS);
					bump    = 1'b1;
					phase_d = PH_SIGNED;
				end else begin
					try_start = 1'b1;
				end
			end
		endcase
		if (try_start) begin
			if ((number_base_q == BASE_AUTO || number_base_q == BASE_HEX) &&
				char_s1 == CH_ZERO) begin
				base_d  = number_base_q;
				bump    = 1'b1;
				phase_d = PH_ZERO;
			end else begin
				dig_base  = (number_base_q == BASE_AUTO) ? BASE_DEC : number_base_q;
				try_digit = 1'b1;
			end
		end
		if (try_digit) begin
			if (dig.ok && dig.val < dig_base) begin
				acc_d   = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(dig.val);
				base_d  = dig_base;
				bump    = 1'b1;
				phase_d = PH_DIGITS;
			end else begin
				emit = 1'b1;
			end
		end
		if (bump) begin
			count_d = count_inc;
		end
		out_data_d = '0;
		out_data_d[VALUE_WIDTH-1:0]           = neg_q ? (VALUE_WIDTH'(0) - acc_q) : acc_q;
		out_data_d[VALUE_WIDTH+:COUNT_WIDTH]  = count_q;
		if (emit) begin
			phase_d = PH_SPACE;
			acc_d   = '0;
			neg_d   = 1'b0;
			base_d  = '0;
			count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			number_base_q <= BASE_RESET;
			phase_q       <= PH_SPACE;
			acc_q         <= '0;
			neg_q         <= 1'b0;
			base_q        <= '0;
			count_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				number_base_q <= cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				base_q  <= base_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
		end
		if (advance && emit) begin
			out_data_q <= out_data_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> phase_q == PH_SPACE && acc_q == '0 && count_q == '0 && !neg_q)
		else $error("parse state not cleared after result");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !emit |=> count_q >= $past(count_q))
		else $error("consumed count decreased within a literal");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ZERO |-> acc_q == '0)
		else $error("accumulator nonzero after leading zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q)
		else $error("input stalled with no item held");

endmodule
